### src/mms_pkg.sv
`default_nettype none

package mms_pkg;

    localparam int unsigned ENC_W   = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned POWER_W = 16;
    localparam int unsigned ACCEL_W = 24;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // acceleration / 1000 as a multiply by a reciprocal: ceil(2^34 / 1000).
    // The rounding error stays below one LSB of the quotient for any 24-bit value.
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] STEP_RECIP = 25'd17179870;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_CONTROL = 2'd1,
        CMD_TIME    = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MOTION_STOP = 2'd0,
        MOTION_FWD  = 2'd1,
        MOTION_BWD  = 2'd2,
        MOTION_NONE = 2'd3
    } motion_t;

    localparam logic [1:0] RESULT_OK          = 2'd0;
    localparam logic [1:0] RESULT_OVERCURRENT = 2'd1;
    localparam logic [1:0] RESULT_TIMEOUT     = 2'd2;

    localparam logic [2:0] EVENT_NONE        = 3'd0;
    localparam logic [2:0] EVENT_OVERCURRENT = 3'd1;
    localparam logic [2:0] EVENT_ZERO_MARK   = 3'd2;
    localparam logic [2:0] EVENT_REACHED     = 3'd3;
    localparam logic [2:0] EVENT_TIMEOUT     = 3'd4;

    localparam logic [1:0] MODE_PLAIN      = 2'd0;
    localparam logic [1:0] MODE_MARK_LEVEL = 2'd1;
    localparam logic [1:0] MODE_MARK_RISE  = 2'd2;
    localparam logic [1:0] MODE_MARK_FALL  = 2'd3;

    localparam logic [1:0] REG_START_POWER  = 2'd0;
    localparam logic [1:0] REG_ACCELERATION = 2'd1;
    localparam logic [1:0] REG_TIME_SYNC    = 2'd2;

    typedef struct packed {
        logic [POWER_W-1:0] start_power;
        logic [POWER_W-1:0] power_step;
        logic               time_sync_enable;
    } cfg_t;

endpackage

`default_nettype wire

### src/motor_move_supervisor.sv
`default_nettype none

// Supervises one encoder-positioned motor move. Each input beat (start, control tick or
// time tick) yields exactly one result beat. A beat is captured in an input register, and
// is evaluated against the move state when the result register can take it, which writes
// the result register; one beat is taken every cycle while the output side keeps up.
// The output register releases the input stage only when it is empty or being drained.
// The per-tick power step (acceleration / 1000) is computed when the acceleration register
// is written and is latched into the move on each start beat.
module motor_move_supervisor (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mms_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [mms_pkg::DATA_W-1:0]         pwdata,
    output logic      [mms_pkg::DATA_W-1:0]         prdata,
    output logic                                    pready,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         cmd,
    input  wire logic signed [mms_pkg::ENC_W-1:0]   encoder_position,
    input  wire logic signed [mms_pkg::ENC_W-1:0]   target_position,
    input  wire logic [mms_pkg::TIME_W-1:0]         timeout_ticks,
    input  wire logic [mms_pkg::POWER_W-1:0]        requested_power,
    input  wire logic [1:0]                         move_mode,
    input  wire logic                               overcurrent,
    input  wire logic                               zero_mark,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              motion,
    output logic [1:0]                              move_result,
    output logic [2:0]                              event_code,
    output logic                                    stop_motor,
    output logic                                    set_power,
    output logic [mms_pkg::POWER_W-1:0]             power_level
);

    mms_pkg::cfg_t cfg;

    mms_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input stage
    logic                              s1_valid_reg;
    mms_pkg::cmd_t                     s1_cmd_reg;
    logic signed [mms_pkg::ENC_W-1:0]  s1_enc_reg;
    logic signed [mms_pkg::ENC_W-1:0]  s1_target_reg;
    logic [mms_pkg::TIME_W-1:0]        s1_timeout_reg;
    logic [mms_pkg::POWER_W-1:0]       s1_req_power_reg;
    logic [1:0]                        s1_mode_reg;
    logic                              s1_oc_reg;
    logic                              s1_zm_reg;

    // Move state
    mms_pkg::motion_t                  motion_reg, motion_next;
    logic [1:0]                        result_reg, result_next;
    logic [mms_pkg::TIME_W-1:0]        move_time_reg, move_time_next;
    logic [mms_pkg::TIME_W-1:0]        timeout_limit_reg, timeout_limit_next;
    logic [mms_pkg::POWER_W-1:0]       total_power_reg, total_power_next;
    logic [mms_pkg::POWER_W-1:0]       goal_power_reg, goal_power_next;
    logic signed [mms_pkg::ENC_W-1:0]  goal_position_reg, goal_position_next;
    logic [1:0]                        active_mode_reg, active_mode_next;
    logic                              prev_zm_reg, prev_zm_next;
    logic [mms_pkg::POWER_W-1:0]       power_step_reg, power_step_next;

    // Result stage
    logic                              out_valid_reg;
    logic [1:0]                        out_motion_reg;
    logic [1:0]                        out_result_reg;
    logic [2:0]                        out_event_reg;
    logic                              out_stop_reg;
    logic                              out_setp_reg;
    logic [mms_pkg::POWER_W-1:0]       out_power_reg;

    logic                              s1_adv;
    logic                              s1_fire;
    logic [2:0]                        event_next;
    logic                              stop_next;
    logic                              setp_next;
    logic                              mark_stop;
    logic                              reached;
    logic [mms_pkg::POWER_W:0]         power_sum;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_cmd_reg       <= mms_pkg::cmd_t'(cmd);
            s1_enc_reg       <= encoder_position;
            s1_target_reg    <= target_position;
            s1_timeout_reg   <= timeout_ticks;
            s1_req_power_reg <= requested_power;
            s1_mode_reg      <= move_mode;
            s1_oc_reg        <= overcurrent;
            s1_zm_reg        <= zero_mark;
        end
    end

    assign power_sum = {1'b0, total_power_reg} + {1'b0, power_step_reg};

    always_comb
    begin
        motion_next        = motion_reg;
        result_next        = result_reg;
        move_time_next     = move_time_reg;
        timeout_limit_next = timeout_limit_reg;
        total_power_next   = total_power_reg;
        goal_power_next    = goal_power_reg;
        goal_position_next = goal_position_reg;
        active_mode_next   = active_mode_reg;
        prev_zm_next       = prev_zm_reg;
        power_step_next    = power_step_reg;
        event_next         = mms_pkg::EVENT_NONE;
        stop_next          = 1'b0;
        setp_next          = 1'b0;

        // A mark level stops the move in level mode; edge modes compare with the last control tick.
        if (s1_zm_reg)
        begin
            mark_stop = (active_mode_reg == mms_pkg::MODE_MARK_LEVEL) ||
                        ((active_mode_reg == mms_pkg::MODE_MARK_RISE) && !prev_zm_reg);
        end
        else
        begin
            mark_stop = (active_mode_reg == mms_pkg::MODE_MARK_FALL) && prev_zm_reg;
        end

        reached = ((motion_reg == mms_pkg::MOTION_FWD) && (s1_enc_reg >= goal_position_reg)) ||
                  ((motion_reg == mms_pkg::MOTION_BWD) && (s1_enc_reg <= goal_position_reg));

        case (s1_cmd_reg)
            mms_pkg::CMD_START:
            begin
                move_time_next     = '0;
                timeout_limit_next = s1_timeout_reg;
                total_power_next   = cfg.start_power;
                goal_power_next    = s1_req_power_reg;
                goal_position_next = s1_target_reg;
                active_mode_next   = s1_mode_reg;
                power_step_next    = cfg.power_step;
                result_next        = mms_pkg::RESULT_OK;
                if (s1_enc_reg < s1_target_reg)
                begin
                    motion_next = mms_pkg::MOTION_FWD;
                end
                else if (s1_enc_reg > s1_target_reg)
                begin
                    motion_next = mms_pkg::MOTION_BWD;
                end
                else
                begin
                    motion_next = mms_pkg::MOTION_STOP;
                end
            end
            mms_pkg::CMD_CONTROL:
            begin
                prev_zm_next = s1_zm_reg;
                if (motion_reg != mms_pkg::MOTION_STOP)
                begin
                    if (s1_oc_reg)
                    begin
                        motion_next = mms_pkg::MOTION_STOP;
                        result_next = mms_pkg::RESULT_OVERCURRENT;
                        event_next  = mms_pkg::EVENT_OVERCURRENT;
                        stop_next   = 1'b1;
                    end
                    else if (mark_stop)
                    begin
                        motion_next = mms_pkg::MOTION_STOP;
                        event_next  = mms_pkg::EVENT_ZERO_MARK;
                        stop_next   = 1'b1;
                    end
                    else if (reached)
                    begin
                        motion_next = mms_pkg::MOTION_STOP;
                        event_next  = mms_pkg::EVENT_REACHED;
                        stop_next   = 1'b1;
                    end
                    else if (move_time_reg >= timeout_limit_reg)
                    begin
                        motion_next = mms_pkg::MOTION_STOP;
                        result_next = mms_pkg::RESULT_TIMEOUT;
                        event_next  = mms_pkg::EVENT_TIMEOUT;
                        stop_next   = 1'b1;
                    end
                    else
                    begin
                        setp_next = 1'b1;
                    end
                end
            end
            mms_pkg::CMD_TIME:
            begin
                if ((motion_reg != mms_pkg::MOTION_STOP) && cfg.time_sync_enable)
                begin
                    if (move_time_reg != '1)
                    begin
                        move_time_next = move_time_reg + 1'b1;
                    end
                    if (total_power_reg < goal_power_reg)
                    begin
                        total_power_next = power_sum[mms_pkg::POWER_W] ? '1 :
                                           power_sum[mms_pkg::POWER_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg        <= mms_pkg::MOTION_STOP;
            result_reg        <= mms_pkg::RESULT_OK;
            move_time_reg     <= '0;
            timeout_limit_reg <= '0;
            total_power_reg   <= '0;
            goal_power_reg    <= '0;
            goal_position_reg <= '0;
            active_mode_reg   <= mms_pkg::MODE_PLAIN;
            prev_zm_reg       <= 1'b0;
            power_step_reg    <= '0;
        end
        else if (s1_fire)
        begin
            motion_reg        <= motion_next;
            result_reg        <= result_next;
            move_time_reg     <= move_time_next;
            timeout_limit_reg <= timeout_limit_next;
            total_power_reg   <= total_power_next;
            goal_power_reg    <= goal_power_next;
            goal_position_reg <= goal_position_next;
            active_mode_reg   <= active_mode_next;
            prev_zm_reg       <= prev_zm_next;
            power_step_reg    <= power_step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_motion_reg <= motion_next;
            out_result_reg <= result_next;
            out_event_reg  <= event_next;
            out_stop_reg   <= stop_next;
            out_setp_reg   <= setp_next;
            out_power_reg  <= total_power_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign motion      = out_motion_reg;
    assign move_result = out_result_reg;
    assign event_code  = out_event_reg;
    assign stop_motor  = out_stop_reg;
    assign set_power   = out_setp_reg;
    assign power_level = out_power_reg;

    a_stop_leaves_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stop_reg |-> out_motion_reg == mms_pkg::MOTION_STOP)
        else $error("stop beat reports a moving motor");

    a_stop_xor_setp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_stop_reg && out_setp_reg))
        else $error("stop and power update in one beat");

    a_event_means_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_event_reg != mms_pkg::EVENT_NONE) == out_stop_reg))
        else $error("event code disagrees with stop flag");

    a_stopped_no_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg == mms_pkg::CMD_TIME) && (motion_reg == mms_pkg::MOTION_STOP)
        |=> $stable(total_power_reg) && $stable(move_time_reg))
        else $error("time beat changed a stopped move");

    a_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("input stage advanced without a result");

endmodule

`default_nettype wire

### src/mms_regs.sv
`default_nettype none

module mms_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mms_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [mms_pkg::DATA_W-1:0]     pwdata,
    output logic      [mms_pkg::DATA_W-1:0]     prdata,
    output logic                                pready,
    output mms_pkg::cfg_t                       cfg
);

    localparam int unsigned PROD_W = mms_pkg::ACCEL_W + mms_pkg::RECIP_W;
    localparam int unsigned QUOT_W = PROD_W - mms_pkg::RECIP_SHIFT;

    logic [mms_pkg::POWER_W-1:0] start_power_reg;
    logic [mms_pkg::ACCEL_W-1:0] acceleration_reg;
    logic                        time_sync_reg;
    logic [mms_pkg::POWER_W-1:0] power_step_reg;

    logic                        wr_en;
    logic [1:0]                  reg_sel;
    logic [PROD_W-1:0]           step_prod;
    logic [mms_pkg::POWER_W-1:0] step_next;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;

    // The step is divided out of the write data and registered beside the rate.
    assign step_prod = PROD_W'(pwdata[mms_pkg::ACCEL_W-1:0]) * PROD_W'(mms_pkg::STEP_RECIP);
    assign step_next = mms_pkg::POWER_W'(step_prod[mms_pkg::RECIP_SHIFT +: QUOT_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_power_reg  <= '0;
            acceleration_reg <= '0;
            time_sync_reg    <= 1'b1;
            power_step_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                mms_pkg::REG_START_POWER:
                begin
                    start_power_reg <= pwdata[mms_pkg::POWER_W-1:0];
                end
                mms_pkg::REG_ACCELERATION:
                begin
                    acceleration_reg <= pwdata[mms_pkg::ACCEL_W-1:0];
                    power_step_reg   <= step_next;
                end
                mms_pkg::REG_TIME_SYNC:
                begin
                    time_sync_reg <= pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            mms_pkg::REG_START_POWER:  prdata = mms_pkg::DATA_W'(start_power_reg);
            mms_pkg::REG_ACCELERATION: prdata = mms_pkg::DATA_W'(acceleration_reg);
            mms_pkg::REG_TIME_SYNC:    prdata = mms_pkg::DATA_W'(time_sync_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.start_power      = start_power_reg;
    assign cfg.power_step       = power_step_reg;
    assign cfg.time_sync_enable = time_sync_reg;

endmodule

`default_nettype wire

### tb/sv/motor_move_supervisor_checker.sv
`timescale 1ns / 100ps

module motor_move_supervisor_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mms_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [mms_pkg::DATA_W-1:0]         pwdata,
    input  wire logic                               pready,

    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic [1:0]                         cmd,
    input  wire logic signed [mms_pkg::ENC_W-1:0]   encoder_position,
    input  wire logic signed [mms_pkg::ENC_W-1:0]   target_position,
    input  wire logic [mms_pkg::TIME_W-1:0]         timeout_ticks,
    input  wire logic [mms_pkg::POWER_W-1:0]        requested_power,
    input  wire logic [1:0]                         move_mode,
    input  wire logic                               overcurrent,
    input  wire logic                               zero_mark,

    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [1:0]                         motion,
    input  wire logic [1:0]                         move_result,
    input  wire logic [2:0]                         event_code,
    input  wire logic                               stop_motor,
    input  wire logic                               set_power,
    input  wire logic [mms_pkg::POWER_W-1:0]        power_level,

    output int                                      fail_count,
    output int                                      pending
);

    typedef struct packed {
        logic [1:0]  motion;
        logic [1:0]  result;
        logic [2:0]  evt;
        logic        stop;
        logic        setp;
        logic [15:0] power;
    } move_beat_t;

    move_beat_t expected_beats[$];
    int         mismatches;
    int         outstanding;

    // Register copies.
    logic [15:0] cfg_start_power;
    logic [23:0] cfg_accel;
    logic        cfg_time_sync;

    // Move state.
    logic [1:0]         mv_motion;
    logic [1:0]         mv_result;
    logic [31:0]        mv_time;
    logic [31:0]        mv_limit;
    logic [15:0]        mv_power;
    logic [15:0]        mv_goal_power;
    logic signed [31:0] mv_goal_pos;
    logic [1:0]         mv_mode;
    logic               mv_last_mark;
    logic [15:0]        mv_step;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        case (index)
            mms_pkg::REG_START_POWER:  cfg_start_power = value[15:0];
            mms_pkg::REG_ACCELERATION: cfg_accel       = value[23:0];
            mms_pkg::REG_TIME_SYNC:    cfg_time_sync   = value[0];
            default: ;
        endcase
    endtask

    task automatic predict_beat();
        move_beat_t  exp;
        logic [16:0] ramped;
        logic        prev_mark;
        logic        mark_stop;
        exp = '0;
        case (cmd)
            mms_pkg::CMD_START: begin
                mv_time       = '0;
                mv_limit      = timeout_ticks;
                mv_power      = cfg_start_power;
                mv_goal_power = requested_power;
                mv_goal_pos   = target_position;
                mv_mode       = move_mode;
                mv_step       = 16'(cfg_accel / 24'd1000);
                mv_result     = mms_pkg::RESULT_OK;
                if (encoder_position < target_position)
                    mv_motion = mms_pkg::MOTION_FWD;
                else if (encoder_position > target_position)
                    mv_motion = mms_pkg::MOTION_BWD;
                else
                    mv_motion = mms_pkg::MOTION_STOP;
            end
            mms_pkg::CMD_CONTROL: begin
                prev_mark    = mv_last_mark;
                mv_last_mark = zero_mark;
                if (overcurrent) begin
                    if (mv_motion != mms_pkg::MOTION_STOP) begin
                        mv_motion = mms_pkg::MOTION_STOP;
                        mv_result = mms_pkg::RESULT_OVERCURRENT;
                        exp.evt   = mms_pkg::EVENT_OVERCURRENT;
                        exp.stop  = 1'b1;
                    end
                end else if (mv_motion != mms_pkg::MOTION_STOP) begin
                    if (zero_mark)
                        mark_stop = (mv_mode == mms_pkg::MODE_MARK_LEVEL) ||
                                    (mv_mode == mms_pkg::MODE_MARK_RISE && !prev_mark);
                    else
                        mark_stop = (mv_mode == mms_pkg::MODE_MARK_FALL) && prev_mark;
                    if (mark_stop) begin
                        mv_motion = mms_pkg::MOTION_STOP;
                        exp.evt   = mms_pkg::EVENT_ZERO_MARK;
                        exp.stop  = 1'b1;
                    end else if ((mv_motion == mms_pkg::MOTION_FWD &&
                                  encoder_position >= mv_goal_pos) ||
                                 (mv_motion == mms_pkg::MOTION_BWD &&
                                  encoder_position <= mv_goal_pos)) begin
                        mv_motion = mms_pkg::MOTION_STOP;
                        exp.evt   = mms_pkg::EVENT_REACHED;
                        exp.stop  = 1'b1;
                    end else if (mv_time >= mv_limit) begin
                        mv_motion = mms_pkg::MOTION_STOP;
                        mv_result = mms_pkg::RESULT_TIMEOUT;
                        exp.evt   = mms_pkg::EVENT_TIMEOUT;
                        exp.stop  = 1'b1;
                    end else begin
                        exp.setp = 1'b1;
                    end
                end
            end
            mms_pkg::CMD_TIME: begin
                if (mv_motion != mms_pkg::MOTION_STOP && cfg_time_sync) begin
                    if (mv_time != 32'hFFFF_FFFF)
                        mv_time = mv_time + 1;
                    // The ramp saturates at full scale and may overshoot the goal by
                    // less than one step.
                    if (mv_power < mv_goal_power) begin
                        ramped   = {1'b0, mv_power} + {1'b0, mv_step};
                        mv_power = ramped[16] ? 16'hFFFF : ramped[15:0];
                    end
                end
            end
            default: ;
        endcase
        exp.motion = mv_motion;
        exp.result = mv_result;
        exp.power  = mv_power;
        expected_beats.push_back(exp);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat();
        move_beat_t exp;
        if (expected_beats.size() == 0) begin
            $error("result beat with no expected result waiting");
            mismatches++;
        end else begin
            exp = expected_beats.pop_front();
            compare_field("motion", exp.motion, motion);
            compare_field("move_result", exp.result, move_result);
            compare_field("event_code", exp.evt, event_code);
            compare_field("stop_motor", exp.stop, stop_motor);
            compare_field("set_power", exp.setp, set_power);
            compare_field("power_level", exp.power, power_level);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_start_power = '0;
            cfg_accel       = '0;
            cfg_time_sync   = 1'b1;
            mv_motion       = mms_pkg::MOTION_STOP;
            mv_result       = mms_pkg::RESULT_OK;
            mv_time         = '0;
            mv_limit        = '0;
            mv_power        = '0;
            mv_goal_power   = '0;
            mv_goal_pos     = '0;
            mv_mode         = mms_pkg::MODE_PLAIN;
            mv_last_mark    = 1'b0;
            mv_step         = '0;
            expected_beats.delete();
            mismatches      = 0;
            outstanding     = 0;
        end else begin
            if (psel && penable && pwrite && pready)
                write_register(paddr[mms_pkg::ADDR_W-1:2], pwdata);
            if (out_valid && out_ready)
                check_beat();
            if (in_valid && in_ready)
                predict_beat();
            outstanding = expected_beats.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int        STALL_LIMIT  = 5000;
    localparam int        PHASE_BEATS  = 200;
    localparam int        PHASES       = 8;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [mms_pkg::ADDR_W-1:0]          paddr;
    logic [mms_pkg::DATA_W-1:0]          pwdata;
    logic [mms_pkg::DATA_W-1:0]          prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_ready;
    logic [1:0]                          cmd;
    logic signed [mms_pkg::ENC_W-1:0]    encoder_position;
    logic signed [mms_pkg::ENC_W-1:0]    target_position;
    logic [mms_pkg::TIME_W-1:0]          timeout_ticks;
    logic [mms_pkg::POWER_W-1:0]         requested_power;
    logic [1:0]                          move_mode;
    logic                                overcurrent;
    logic                                zero_mark;
    logic                                out_valid;
    logic                                out_ready;
    logic [1:0]                          motion;
    logic [1:0]                          move_result;
    logic [2:0]                          event_code;
    logic                                stop_motor;
    logic                                set_power;
    logic [mms_pkg::POWER_W-1:0]         power_level;

    int fail_count;
    int pending;
    int beats_sent;
    int idle_cycles;
    bit steady;

    motor_move_supervisor dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .encoder_position (encoder_position),
        .target_position  (target_position),
        .timeout_ticks    (timeout_ticks),
        .requested_power  (requested_power),
        .move_mode        (move_mode),
        .overcurrent      (overcurrent),
        .zero_mark        (zero_mark),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .motion           (motion),
        .move_result      (move_result),
        .event_code       (event_code),
        .stop_motor       (stop_motor),
        .set_power        (set_power),
        .power_level      (power_level)
    );

    motor_move_supervisor_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .encoder_position (encoder_position),
        .target_position  (target_position),
        .timeout_ticks    (timeout_ticks),
        .requested_power  (requested_power),
        .move_mode        (move_mode),
        .overcurrent      (overcurrent),
        .zero_mark        (zero_mark),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .motion           (motion),
        .move_result      (move_result),
        .event_code       (event_code),
        .stop_motor       (stop_motor),
        .set_power        (set_power),
        .power_level      (power_level),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    initial
    begin : result_sink
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                out_ready = 1'b1;
                hold = 0;
            end
            else if (hold > 0)
                hold--;
            else if (out_ready)
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    out_ready = 1'b0;
                    hold--;
                end
                else
                    hold = $urandom_range(0, 11);
            end
            else
            begin
                out_ready = 1'b1;
                hold = $urandom_range(0, 11);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_settings(input logic [15:0] power, input logic [23:0] accel,
                                 input logic sync);
        reg_write(mms_pkg::REG_START_POWER, {16'h0, power});
        reg_write(mms_pkg::REG_ACCELERATION, {8'h0, accel});
        reg_write(mms_pkg::REG_TIME_SYNC, {31'h0, sync});
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so that the next beat can follow back to back.
    task automatic send_beat(input mms_pkg::cmd_t c, input logic [31:0] enc,
                             input logic [31:0] tgt, input logic [31:0] ticks,
                             input logic [15:0] power, input logic [1:0] mode,
                             input logic oc, input logic zm);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd              = c;
        encoder_position = enc;
        target_position  = tgt;
        timeout_ticks    = ticks;
        requested_power  = power;
        move_mode        = mode;
        overcurrent      = oc;
        zero_mark        = zm;
        in_valid         = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_random(input mms_pkg::cmd_t c, input logic [31:0] enc,
                               input logic oc, input logic zm);
        send_beat(c, enc, $urandom, $urandom, 16'($urandom), 2'($urandom), oc, zm);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // A start followed by a run of ticks, with the encoder walking toward the target.
    task automatic run_move();
        logic [31:0] enc;
        logic [31:0] tgt;
        logic [31:0] ticks;
        logic [15:0] power;
        logic        zm;
        int          r;
        int          n;
        enc = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
        r = $urandom_range(0, 9);
        if (r == 0)
            tgt = enc;
        else if (r == 1)
            tgt = $urandom;
        else
            tgt = enc + $urandom_range(0, 100) - 50;
        r = $urandom_range(0, 9);
        if (r < 7)
            ticks = $urandom_range(0, 15);
        else if (r < 9)
            ticks = $urandom_range(16, 200);
        else
            ticks = $urandom;
        power = ($urandom_range(0, 9) < 3) ? 16'hFFFF : 16'($urandom);
        send_beat(mms_pkg::CMD_START, enc, tgt, ticks, power, 2'($urandom),
                  1'($urandom), 1'($urandom));
        zm = 1'($urandom);
        n = $urandom_range(3, 30);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_random(mms_pkg::CMD_TIME, $urandom, 1'($urandom), 1'($urandom));
            else if (r < 95)
            begin
                if ($signed(tgt) > $signed(enc))
                    enc = enc + $urandom_range(0, 8);
                else if ($signed(tgt) < $signed(enc))
                    enc = enc - $urandom_range(0, 8);
                if ($urandom_range(0, 4) == 0)
                    zm = !zm;
                send_random(mms_pkg::CMD_CONTROL, enc, $urandom_range(0, 39) == 0, zm);
            end
            else
                send_random(mms_pkg::CMD_UNUSED, $urandom, 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(2, 6))
            send_random(mms_pkg::cmd_t'($urandom_range(0, 3)), $urandom,
                        1'($urandom), 1'($urandom));
    endtask

    initial
    begin : stimulus
        int phase;
        int goal;
        int r;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        cmd              = mms_pkg::CMD_START;
        encoder_position = '0;
        target_position  = '0;
        timeout_ticks    = '0;
        requested_power  = '0;
        move_mode        = mms_pkg::MODE_PLAIN;
        overcurrent      = 1'b0;
        zero_mark        = 1'b0;
        beats_sent       = 0;
        idle_cycles      = 0;
        steady           = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: power step of 5 per time tick, starting from 100.
        load_settings(16'd100, 24'd5000, 1'b1);
        send_beat(mms_pkg::CMD_CONTROL, 0, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b1, 1'b1);
        send_beat(mms_pkg::CMD_UNUSED, '1, '1, '1, '1, mms_pkg::MODE_MARK_FALL, 1'b1, 1'b1);
        send_beat(mms_pkg::CMD_TIME, 0, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_START, 32'h8000_0000, 32'h7FFF_FFFF, 2, 16'hFFFF,
                  mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_TIME, 0, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_TIME, 0, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 0, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_START, 32'h7FFF_FFFF, 32'h8000_0000, '1, 0,
                  mms_pkg::MODE_MARK_LEVEL, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_TIME, 0, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 0, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b1);
        send_beat(mms_pkg::CMD_START, 5, 5, 10, 50, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 5, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b1, 1'b0);
        send_beat(mms_pkg::CMD_START, 0, 100, '1, 200, mms_pkg::MODE_MARK_RISE, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 10, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 20, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b1);
        send_beat(mms_pkg::CMD_START, 0, 100, '1, 200, mms_pkg::MODE_MARK_FALL, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 10, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b1);
        send_beat(mms_pkg::CMD_CONTROL, 20, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_START, 0, 100, '1, 200, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 100, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_START, 100, 0, '1, 200, mms_pkg::MODE_MARK_RISE, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 50, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, -5, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_START, 0, 100, '1, 200, mms_pkg::MODE_PLAIN, 1'b0, 1'b0);
        send_beat(mms_pkg::CMD_CONTROL, 10, 0, 0, 0, mms_pkg::MODE_PLAIN, 1'b1, 1'b0);
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: load_settings(16'd0, 24'd0, 1'b1);
                1: load_settings(16'hFFFF, 24'hFF_FFFF, 1'b1);
                2: load_settings(16'($urandom), 24'd999, 1'b1);
                3: load_settings(16'($urandom), 24'd1000, 1'b0);
                4: load_settings(16'($urandom_range(0, 300)), 24'($urandom), 1'b1);
                5: load_settings(16'd65000, 24'($urandom), 1'b1);
                6: load_settings(16'($urandom), 24'($urandom), 1'($urandom));
                default:
                begin
                    load_settings(16'd12, 24'd2000, 1'b1);
                    reg_write(REG_UNMAPPED, $urandom);
                end
            endcase
            // Two phases run with both sides at full rate.
            steady = (phase == 2 || phase == 5);
            goal = beats_sent + PHASE_BEATS;
            while (beats_sent < goal)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    run_noise();
                else if (r < 12)
                    drain();
                else
                    run_move();
            end
            drain();
        end
        steady = 1'b0;

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
